/* rtl/core/ugf_pkg.sv */
// Shared types, constants and code point range check for the UTF-8 glyph filter.
package ugf_pkg;

	localparam int unsigned MaxResults = 5;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned NumWidth   = $clog2(MaxResults + 1);

	localparam logic [7:0] CapReset   = 8'd48;
	localparam logic [7:0] QMark      = 8'h3F;
	localparam logic [7:0] EndByte    = 8'h00;
	localparam logic [7:0] CtrlLimit  = 8'h20;
	localparam logic [7:0] DelByte    = 8'h7F;
	localparam logic [7:0] AsciiLimit = 8'h80;

	localparam logic [15:0] CpLatinLo = 16'h00A0;
	localparam logic [15:0] CpLatinHi = 16'h017F;
	localparam logic [15:0] CpExtBLo  = 16'h01A0;
	localparam logic [15:0] CpExtBHi  = 16'h01B0;
	localparam logic [15:0] CpVietLo  = 16'h1EA0;
	localparam logic [15:0] CpVietHi  = 16'h1EF9;
	localparam logic [15:0] CpPunctLo = 16'h2010;
	localparam logic [15:0] CpPunctHi = 16'h2026;
	localparam logic [15:0] CpDong    = 16'h20AB;
	localparam logic [15:0] CpMin2    = 16'h0080;
	localparam logic [15:0] CpMin3    = 16'h0800;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_present;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_end;
	} out_item_t;

	typedef struct packed {
		logic [NumWidth-1:0]           n;
		logic [MaxResults-1:0][7:0]    bytes;
		logic                          has_end;
	} job_t;

	function automatic logic cp_supported(input logic [15:0] cp);
		cp_supported = (cp >= CpLatinLo && cp <= CpLatinHi)
			|| (cp >= CpExtBLo && cp <= CpExtBHi)
			|| (cp >= CpVietLo && cp <= CpVietHi)
			|| (cp >= CpPunctLo && cp <= CpPunctHi)
			|| (cp == CpDong);
	endfunction

endpackage

/* rtl/core/utf8_glyph_filter.sv */
// Top level of the UTF-8 glyph filter.
// The bytes of an accepted item are registered in the job queue and then in the output register.
// Throughput: one item per clock while the job queue is not full; an item yielding k bytes
// holds the output until all k are sent, a four-entry job queue absorbing up to four jobs.
// Reset clears the emitted count and sequence state except held_q; the capacity resets to 48.
module utf8_glyph_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ugf_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ugf_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import ugf_pkg::*;

	logic q_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head;

	assign in_stall  = q_full;
	assign cfg_ready = 1'b1;

	ugf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_valid && !in_stall),
		.item     (in_data),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.push     (push),
		.job      (push_job)
	);

	ugf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	ugf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

/* rtl/core/ugf_front.sv */
// Front end: accepts bytes, tracks the pending sequence and builds one output job per item that yields bytes.
module ugf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  ugf_pkg::in_item_t item,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_data,
	output logic              push,
	output ugf_pkg::job_t     job
);
	import ugf_pkg::*;

	typedef struct packed {
		logic [NumWidth-1:0]        n;
		logic [MaxResults-1:0][7:0] b;
		logic [7:0]                 ec;
		logic                       full;
	} acc_t;

	logic [7:0]      cap_q;
	logic [7:0]      lead_q;
	logic [1:0][7:0] held_q;
	logic [1:0]      hc_q;
	logic [1:0]      el_q;
	logic [7:0]      ec_q;
	logic            full_q;

	logic [7:0]      lead_d;
	logic [1:0][7:0] held_d;
	logic [1:0]      hc_d;
	logic [1:0]      el_d;
	acc_t            acc;
	logic            end_d;

	function automatic acc_t acc_put(input acc_t a, input logic [7:0] v);
		acc_t r;
		r = a;
		r.b[r.n] = v;
		r.n = r.n + NumWidth'(1);
		r.ec = r.ec + 8'd1;
		return r;
	endfunction

	function automatic logic has_room(input acc_t a, input logic [7:0] cap);
		return !a.full && (({1'b0, a.ec} + 9'd4) < {1'b0, cap});
	endfunction

	function automatic acc_t acc_abandon(input acc_t a, input logic [1:0] cnt,
			input logic [7:0] cap);
		acc_t r;
		logic go;
		r = acc_put(a, QMark);
		go = 1'b1;
		if (cnt >= 2'd1) begin
			if (has_room(r, cap)) begin
				r = acc_put(r, QMark);
			end else begin
				r.full = 1'b1;
				go = 1'b0;
			end
		end
		if (cnt >= 2'd2 && go) begin
			if (has_room(r, cap)) begin
				r = acc_put(r, QMark);
			end else begin
				r.full = 1'b1;
			end
		end
		return r;
	endfunction

	logic [7:0]  c;
	logic        cont;
	logic [10:0] cp2;
	logic [15:0] cp3;

	assign c    = item.in_byte;
	assign cont = (c[7:6] == 2'b10);
	assign cp2  = {lead_q[4:0], c[5:0]};
	assign cp3  = {lead_q[3:0], held_q[0][5:0], c[5:0]};

	always_comb begin
		acc    = '{n: '0, b: '0, ec: ec_q, full: full_q};
		lead_d = lead_q;
		held_d = held_q;
		hc_d   = hc_q;
		el_d   = el_q;
		end_d  = 1'b0;
		if (item.byte_present) begin
			if (el_d != 2'd0 && cont) begin
				if ((({1'b0, hc_d} + 3'd1) < {1'b0, el_d}) && hc_d < 2'd2) begin
					held_d[hc_d[0]] = c;
					hc_d = hc_d + 2'd1;
				end else begin
					priority if (el_d == 2'd1) begin
						if ({5'd0, cp2} >= CpMin2 && cp_supported({5'd0, cp2})) begin
							acc = acc_put(acc, lead_q);
							acc = acc_put(acc, c);
						end else begin
							acc = acc_put(acc, QMark);
						end
					end else if (el_d == 2'd2) begin
						if (cp3 >= CpMin3 && cp_supported(cp3)) begin
							acc = acc_put(acc, lead_q);
							acc = acc_put(acc, held_q[0]);
							acc = acc_put(acc, c);
						end else begin
							acc = acc_put(acc, QMark);
						end
					end else begin
						acc = acc_put(acc, QMark);
					end
					el_d = 2'd0;
					hc_d = 2'd0;
				end
			end else begin
				if (el_d != 2'd0) begin
					acc  = acc_abandon(acc, hc_d, cap_q);
					el_d = 2'd0;
					hc_d = 2'd0;
				end
				if (!has_room(acc, cap_q)) begin
					acc.full = 1'b1;
				end else if (c < CtrlLimit || c == DelByte) begin
					acc.full = acc.full;
				end else if (c < AsciiLimit) begin
					acc = acc_put(acc, c);
				end else begin
					hc_d = 2'd0;
					priority if (c[7:5] == 3'b110) begin
						lead_d = c;
						el_d   = 2'd1;
					end else if (c[7:4] == 4'b1110) begin
						lead_d = c;
						el_d   = 2'd2;
					end else if (c[7:3] == 5'b11110) begin
						lead_d = c;
						el_d   = 2'd3;
					end else begin
						acc = acc_put(acc, QMark);
					end
				end
			end
		end
		if (item.is_last) begin
			if (el_d != 2'd0) begin
				acc = acc_abandon(acc, hc_d, cap_q);
			end
			acc      = acc_put(acc, EndByte);
			end_d    = 1'b1;
			lead_d   = '0;
			held_d   = '0;
			hc_d     = '0;
			el_d     = '0;
			acc.ec   = '0;
			acc.full = 1'b0;
		end
	end

	assign push = accept && (acc.n != '0);
	assign job  = '{n: acc.n, bytes: acc.b, has_end: end_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CapReset;
			lead_q <= '0;
			hc_q   <= '0;
			el_q   <= '0;
			ec_q   <= '0;
			full_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				lead_q <= lead_d;
				hc_q   <= hc_d;
				el_q   <= el_d;
				ec_q   <= acc.ec;
				full_q <= acc.full;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

endmodule

/* rtl/core/ugf_queue.sv */
// Job queue between the front end and the byte emitter.
module ugf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ugf_pkg::job_t push_job,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output ugf_pkg::job_t head
);
	import ugf_pkg::*;

	localparam int unsigned Aw = $clog2(QueueDepth);
	localparam int unsigned Cw = $clog2(QueueDepth + 1);

	job_t [QueueDepth-1:0] entries_q;
	logic [Aw-1:0]         wr_ptr_q;
	logic [Aw-1:0]         rd_ptr_q;
	logic [Cw-1:0]         count_q;

	assign full       = (count_q == Cw'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Aw'(QueueDepth - 1)) ? '0 : wr_ptr_q + Aw'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Aw'(QueueDepth - 1)) ? '0 : rd_ptr_q + Aw'(1);
			end
			count_q <= count_q + Cw'(push) - Cw'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* rtl/core/ugf_back.sv */
// Back end: walks the head job one byte per cycle, while the output is not stalled, into the output register.
module ugf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ugf_pkg::job_t       head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output ugf_pkg::out_item_t  out_data
);
	import ugf_pkg::*;

	logic [NumWidth-1:0] idx_q;
	logic                valid_q;
	out_item_t           data_q;
	logic                advance;
	logic                last_byte;

	assign advance   = !valid_q || !out_stall;
	assign last_byte = (idx_q == head.n - NumWidth'(1));
	assign pop       = advance && head_valid && last_byte;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= last_byte ? '0 : idx_q + NumWidth'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			data_q.out_byte <= head.bytes[idx_q];
			data_q.is_end   <= head.has_end && last_byte;
		end
	end

endmodule

/* rtl/core/ugf_checker.sv */
// Port-level checks for the UTF-8 glyph filter and their binding.
module ugf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input ugf_pkg::out_item_t out_data
);
	import ugf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output transaction changed");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_end |-> out_data.out_byte == EndByte)
		else $error("end marker carries a nonzero byte");

	a_no_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_end |->
			out_data.out_byte >= CtrlLimit && out_data.out_byte != DelByte)
		else $error("control byte emitted");

endmodule

bind utf8_glyph_filter ugf_checker u_ugf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* tb/tb.sv */
// Self-checking testbench for utf8_glyph_filter: predicts every cleaned byte and checks the stream.
module tb;
	import ugf_pkg::*;

	localparam int IdleLimit    = 1000;
	localparam int SettleCycles = 16;
	localparam int HoldCycles   = 80;

	class glyph_ledger;
		logic [7:0] capacity;
		logic [7:0] lead;
		logic [7:0] held[2];
		int         held_cnt;
		int         need;
		logic [7:0] emitted;
		bit         full;
		out_item_t  pending_glyphs[$];
		int         errors;

		function new();
			capacity = CapReset;
			errors = 0;
			clear_string();
		endfunction

		function void clear_string();
			lead = '0;
			held[0] = '0;
			held[1] = '0;
			held_cnt = 0;
			need = 0;
			emitted = '0;
			full = 1'b0;
		endfunction

		function void emit(logic [7:0] b);
			out_item_t g;
			g.out_byte = b;
			g.is_end = 1'b0;
			pending_glyphs.push_back(g);
			emitted = emitted + 8'd1;
		endfunction

		function bit has_room();
			if (full)
				return 1'b0;
			if (int'(emitted) + 4 < int'(capacity))
				return 1'b1;
			full = 1'b1;
			return 1'b0;
		endfunction

		function bit in_range(int cp);
			return (cp >= CpLatinLo && cp <= CpLatinHi) || (cp >= CpExtBLo && cp <= CpExtBHi)
				|| (cp >= CpVietLo && cp <= CpVietHi) || (cp >= CpPunctLo && cp <= CpPunctHi)
				|| (cp == CpDong);
		endfunction

		function void start_fresh(logic [7:0] c);
			if (!has_room())
				return;
			if (c < CtrlLimit || c == DelByte)
				return;
			if (c < AsciiLimit) begin
				emit(c);
				return;
			end
			held_cnt = 0;
			if (c[7:5] == 3'b110) begin
				lead = c;
				need = 1;
			end else if (c[7:4] == 4'b1110) begin
				lead = c;
				need = 2;
			end else if (c[7:3] == 5'b11110) begin
				lead = c;
				need = 3;
			end else begin
				emit(QMark);
			end
		endfunction

		function void drop_pending();
			int cnt;
			cnt = held_cnt;
			emit(QMark);
			need = 0;
			held_cnt = 0;
			for (int k = 0; k < cnt && k < 2; k++) begin
				if (!has_room())
					return;
				emit(QMark);
			end
		endfunction

		function void finish_seq(logic [7:0] c);
			int cp;
			if (need == 1) begin
				cp = {lead[4:0], c[5:0]};
				if (cp >= CpMin2 && in_range(cp)) begin
					emit(lead);
					emit(c);
				end else begin
					emit(QMark);
				end
			end else if (need == 2) begin
				cp = {lead[3:0], held[0][5:0], c[5:0]};
				if (cp >= CpMin3 && in_range(cp)) begin
					emit(lead);
					emit(held[0]);
					emit(c);
				end else begin
					emit(QMark);
				end
			end else begin
				emit(QMark);
			end
			need = 0;
			held_cnt = 0;
		endfunction

		function void take_byte(logic [7:0] c);
			if (need == 0) begin
				start_fresh(c);
				return;
			end
			if (c[7:6] == 2'b10) begin
				if (held_cnt + 1 < need && held_cnt < 2) begin
					held[held_cnt] = c;
					held_cnt++;
				end else begin
					finish_seq(c);
				end
				return;
			end
			drop_pending();
			start_fresh(c);
		endfunction

		function void note_byte_item(in_item_t it);
			out_item_t marker;
			if (it.byte_present)
				take_byte(it.in_byte);
			if (it.is_last) begin
				if (need != 0)
					drop_pending();
				marker.out_byte = EndByte;
				marker.is_end = 1'b1;
				pending_glyphs.push_back(marker);
				clear_string();
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_glyph(out_item_t got);
			out_item_t want;
			if (pending_glyphs.size() == 0) begin
				report($sformatf("unexpected byte %h end %b", got.out_byte, got.is_end));
				return;
			end
			want = pending_glyphs.pop_front();
			if (got.out_byte !== want.out_byte)
				report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
			if (got.is_end !== want.is_end)
				report($sformatf("is_end %b, want %b", got.is_end, want.is_end));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	glyph_ledger ledger;
	int send_idle = 0;
	int recv_idle = 0;
	int items_done = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	utf8_glyph_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HoldCycles;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.check_glyph(out_data);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IdleLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic offer_item(input in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ledger.note_byte_item(it);
		if (it.byte_present || it.is_last)
			items_done++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit last);
		offer_item(in_item_t'{in_byte: b, byte_present: 1'b1, is_last: last});
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (ledger.pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [7:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		ledger.capacity = value;
	endtask

	task automatic random_string(input int max_tokens);
		logic [7:0] seq[$];
		logic [15:0] cp;
		int pick;
		int lead_len;
		int close_how;
		repeat ($urandom_range(max_tokens, 1)) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				seq.push_back(8'($urandom_range(8'h7E, 8'h20)));
			end else if (pick < 36) begin
				seq.push_back(pick == 35 ? DelByte : 8'($urandom_range(8'h1F, 0)));
			end else if (pick < 56) begin
				if (pick < 50)
					cp = 16'($urandom_range(CpLatinHi, CpLatinLo));
				else
					cp = 16'($urandom_range(CpExtBHi, CpExtBLo));
				seq.push_back({3'b110, cp[10:6]});
				seq.push_back({2'b10, cp[5:0]});
			end else if (pick < 71) begin
				case ($urandom_range(2))
					0: cp = 16'($urandom_range(CpVietHi, CpVietLo));
					1: cp = 16'($urandom_range(CpPunctHi, CpPunctLo));
					default: cp = CpDong;
				endcase
				seq.push_back({4'b1110, cp[15:12]});
				seq.push_back({2'b10, cp[11:6]});
				seq.push_back({2'b10, cp[5:0]});
			end else if (pick < 77) begin
				seq.push_back({3'b110, 5'($urandom)});
				seq.push_back({2'b10, 6'($urandom)});
			end else if (pick < 83) begin
				seq.push_back({4'b1110, 4'($urandom)});
				repeat (2) seq.push_back({2'b10, 6'($urandom)});
			end else if (pick < 87) begin
				seq.push_back({5'b11110, 3'($urandom)});
				repeat (3) seq.push_back({2'b10, 6'($urandom)});
			end else if (pick < 91) begin
				if ($urandom_range(1))
					seq.push_back({2'b10, 6'($urandom)});
				else
					seq.push_back({5'b11111, 3'($urandom)});
			end else if (pick < 98) begin
				lead_len = $urandom_range(2);
				case (lead_len)
					0: seq.push_back({3'b110, 5'($urandom)});
					1: seq.push_back({4'b1110, 4'($urandom)});
					default: seq.push_back({5'b11110, 3'($urandom)});
				endcase
				repeat ($urandom_range(lead_len)) seq.push_back({2'b10, 6'($urandom)});
			end else begin
				seq.push_back(8'($urandom));
			end
		end
		close_how = $urandom_range(7);
		foreach (seq[i]) begin
			if ($urandom_range(14) == 0)
				offer_item(in_item_t'{in_byte: 8'($urandom), byte_present: 1'b0, is_last: 1'b0});
			send_byte(seq[i], close_how > 1 && i == seq.size() - 1);
		end
		if (close_how == 1)
			offer_item(in_item_t'{in_byte: 8'($urandom), byte_present: 1'b0, is_last: 1'b1});
	endtask

	task automatic run_phase(input logic [7:0] cap, input int s_idle, input int r_idle,
			input int count, input int max_tokens, input bit squeeze);
		int target;
		write_capacity(cap);
		send_idle = s_idle;
		recv_idle = r_idle;
		hold_req = squeeze;
		target = items_done + count;
		while (items_done < target)
			random_string(max_tokens);
	endtask

	initial begin
		logic [7:0] opening[$];
		ledger = new();
		opening = {8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'hC2, 8'hA0, 8'hC0, 8'h80,
			8'hE1, 8'hBA, 8'hA0, 8'hE2, 8'h82, 8'hAB, 8'hED, 8'hA0, 8'h80,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF, 8'hE1, 8'hBA, 8'h41, 8'hC3};
		send_idle = 17;
		recv_idle = 48;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening[i])
			send_byte(opening[i], i == opening.size() - 1);
		offer_item(in_item_t'{in_byte: 8'hA5, byte_present: 1'b0, is_last: 1'b1});
		offer_item(in_item_t'{in_byte: 8'h5A, byte_present: 1'b0, is_last: 1'b0});

		run_phase(8'd20, 17, 48, 65, 12, 1'b0);
		run_phase(8'd255, 48, 17, 55, 30, 1'b0);
		run_phase(8'd1, 48, 17, 20, 8, 1'b0);
		run_phase(8'($urandom_range(40, 5)), 0, 0, 50, 12, 1'b1);

		settle();
		if (ledger.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ugf_pkg.sv
rtl/core/ugf_front.sv
rtl/core/ugf_queue.sv
rtl/core/ugf_back.sv
rtl/core/utf8_glyph_filter.sv
rtl/core/ugf_checker.sv
tb/tb.sv
